// File: rtl/ugc_pkg.sv
// ----------------------------------------------------------------------------
// ugc_pkg: shared types, constants and glyph-set tables
// UTF-8 decode limits, Hangul split constants and the 8x4x4 set selection.
// ----------------------------------------------------------------------------
package ugc_pkg;

   // default depth of the queue between the decoder and the glyph emitter
   localparam int unsigned QUEUE_DEPTH = 4;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN_X = 2'd0,
      CSR_ORIGIN_Y = 2'd1,
      CSR_INK      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [15:0] ink;
   } csr_type;

   // UTF-8 byte classes
   localparam logic [7:0] BYTE_ASCII_END = 8'h80;
   localparam logic [7:0] BYTE_LEAD2     = 8'hC0;
   localparam logic [7:0] BYTE_LEAD3     = 8'hE0;
   localparam logic [7:0] BYTE_LEAD4     = 8'hF0;

   // code points
   localparam logic [15:0] HANGUL_FIRST = 16'hAC00;
   localparam logic [15:0] HANGUL_LAST  = 16'hD7A3;
   localparam logic [15:0] CODE_NUL     = 16'h0000;
   localparam logic [15:0] CODE_LF      = 16'h000A;
   localparam logic [15:0] CODE_CR      = 16'h000D;
   localparam logic [15:0] SINGLE_LIMIT = 16'h0100;

   // pen steps
   localparam logic [15:0] STEP_HANGUL = 16'd16;
   localparam logic [15:0] STEP_SINGLE = 16'd8;
   localparam logic [15:0] STEP_LINE   = 16'd16;

   // syllable split: off / 588 and rem / 28 by reciprocal multiplication
   localparam int unsigned JAMO_PER_INI = 588;
   localparam int unsigned FIN_PER_MED  = 28;
   localparam int unsigned INI_RECIP    = 28533;
   localparam int unsigned INI_SHIFT    = 24;
   localparam int unsigned MED_RECIP    = 586;
   localparam int unsigned MED_SHIFT    = 14;

   // one decoded glyph job from the front to the back
   typedef struct packed {
      logic        hangul;
      logic [13:0] val;     // syllable offset, or the single-byte code
      logic [15:0] cur_x;
      logic [15:0] cur_y;
   } glyph_job_type;

   typedef enum logic [1:0] {
      SLOT_INITIAL = 2'd0,
      SLOT_MEDIAL  = 2'd1,
      SLOT_FINAL   = 2'd2
   } jamo_slot_type;

   function automatic logic [3:0] initial_glyph_set(logic [4:0] med, logic [4:0] fin);
      logic hf;
      logic [3:0] s;
      hf = (fin != 5'd0);
      if (med < 5'd8 || med == 5'd20) begin
         s = hf ? 4'd5 : 4'd0;
      end else if (med == 5'd8 || med == 5'd12 || med == 5'd18) begin
         s = hf ? 4'd6 : 4'd1;
      end else if (med == 5'd13 || med == 5'd17) begin
         s = hf ? 4'd6 : 4'd2;
      end else if ((med > 5'd8 && med < 5'd12) || med == 5'd19) begin
         s = hf ? 4'd7 : 4'd3;
      end else begin
         s = hf ? 4'd7 : 4'd4;
      end
      return s;
   endfunction

   function automatic logic [3:0] medial_glyph_set(logic [4:0] ini, logic [4:0] fin);
      logic [3:0] s;
      s = (ini == 5'd0 || ini == 5'd15) ? 4'd8 : 4'd9;
      if (fin != 5'd0) begin
         s = s + 4'd2;
      end
      return s;
   endfunction

   function automatic logic [3:0] final_glyph_set(logic [4:0] med);
      logic [3:0] s;
      if (med == 5'd0 || med == 5'd2 || med == 5'd9) begin
         s = 4'd12;
      end else if (med == 5'd4 || med == 5'd6 || med == 5'd11 || med == 5'd14 ||
                   med == 5'd16 || med == 5'd19 || med == 5'd20) begin
         s = 4'd13;
      end else if ((med[0] && med < 5'd8) || med == 5'd10 || med == 5'd15) begin
         s = 4'd14;
      end else begin
         s = 4'd15;
      end
      return s;
   endfunction

endpackage

// File: rtl/ugc_req_if.sv
// ----------------------------------------------------------------------------
// ugc_req_if: byte request channel
// Carries one raw UTF-8 byte and the start-of-text flag per transaction.
// ----------------------------------------------------------------------------
interface ugc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;

   modport source (output valid, output data_byte, output start_req, input ready);
   modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

// File: rtl/ugc_rsp_if.sv
// ----------------------------------------------------------------------------
// ugc_rsp_if: glyph command channel
// Carries one font-ROM glyph command with its pen position per transaction.
// ----------------------------------------------------------------------------
interface ugc_rsp_if;
   logic        valid;
   logic        ready;
   logic        font_select;
   logic [13:0] glyph_base;
   logic [15:0] draw_x;
   logic [15:0] draw_y;
   logic [15:0] ink;
   logic        last;

   modport source (output valid, output font_select, output glyph_base, output draw_x,
                   output draw_y, output ink, output last, input ready);
   modport sink   (input valid, input font_select, input glyph_base, input draw_x,
                   input draw_y, input ink, input last, output ready);
endinterface

// File: rtl/ugc_front.sv
// ----------------------------------------------------------------------------
// ugc_front: UTF-8 decoder and pen tracker
// Accepts bytes, assembles code points, moves the pen and queues glyph jobs.
// ----------------------------------------------------------------------------
module ugc_front (
   input  logic                       clock,
   input  logic                       reset,
   ugc_req_if.sink                    req,
   input  logic                       q_full,
   output logic                       q_push,
   output ugc_pkg::glyph_job_type     q_job
);

   logic        ended_ff, ended_in;
   logic [1:0]  left_ff, left_in;
   logic [15:0] part_ff, part_in;
   logic [15:0] cx_ff, cx_in;
   logic [15:0] cy_ff, cy_in;

   logic        accept;
   logic        ended_e;
   logic [1:0]  left_e;
   logic [15:0] part_e, cx_e, cy_e;
   logic [15:0] part_new;
   logic [15:0] code;
   logic        code_done;
   logic [7:0]  b;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.data_byte;

   always_comb begin
      // start of text clears the decoder before the byte is looked at
      ended_e = req.start_req ? 1'b0  : ended_ff;
      left_e  = req.start_req ? 2'd0  : left_ff;
      part_e  = req.start_req ? 16'd0 : part_ff;
      cx_e    = req.start_req ? 16'd0 : cx_ff;
      cy_e    = req.start_req ? 16'd0 : cy_ff;
      part_new = {part_e[9:0], b[5:0]};

      ended_in  = ended_ff;
      left_in   = left_ff;
      part_in   = part_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      code      = 16'd0;
      code_done = 1'b0;
      q_push    = 1'b0;
      q_job.hangul = 1'b0;
      q_job.val    = 14'd0;
      q_job.cur_x  = cx_e;
      q_job.cur_y  = cy_e;

      if (accept) begin
         ended_in = ended_e;
         left_in  = left_e;
         part_in  = part_e;
         cx_in    = cx_e;
         cy_in    = cy_e;
         if (!ended_e) begin
            if (left_e != 2'd0) begin
               part_in = part_new;
               left_in = left_e - 2'd1;
               if (left_e == 2'd1) begin
                  code      = part_new;
                  code_done = 1'b1;
               end
            end else if (b < ugc_pkg::BYTE_ASCII_END) begin
               code      = {8'd0, b};
               code_done = 1'b1;
            end else if (b < ugc_pkg::BYTE_LEAD2 || b > ugc_pkg::BYTE_LEAD4) begin
               ended_in = 1'b1;
            end else if (b < ugc_pkg::BYTE_LEAD3) begin
               part_in = {11'd0, b[4:0]};
               left_in = 2'd1;
            end else if (b < ugc_pkg::BYTE_LEAD4) begin
               part_in = {12'd0, b[3:0]};
               left_in = 2'd2;
            end else begin
               part_in = 16'd0;
               left_in = 2'd3;
            end
         end

         if (code_done) begin
            if (code == ugc_pkg::CODE_NUL) begin
               ended_in = 1'b1;
            end else if (code >= ugc_pkg::HANGUL_FIRST && code <= ugc_pkg::HANGUL_LAST) begin
               q_push       = 1'b1;
               q_job.hangul = 1'b1;
               q_job.val    = 14'(code - ugc_pkg::HANGUL_FIRST);
               cx_in        = cx_e + ugc_pkg::STEP_HANGUL;
            end else if (code == ugc_pkg::CODE_LF) begin
               cy_in = cy_e + ugc_pkg::STEP_LINE;
            end else if (code == ugc_pkg::CODE_CR) begin
               cx_in = 16'd0;
            end else if (code < ugc_pkg::SINGLE_LIMIT) begin
               q_push    = 1'b1;
               q_job.val = {6'd0, code[7:0]};
               cx_in     = cx_e + ugc_pkg::STEP_SINGLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ended_ff <= 1'b0;
         left_ff  <= 2'd0;
         part_ff  <= 16'd0;
         cx_ff    <= 16'd0;
         cy_ff    <= 16'd0;
      end else begin
         ended_ff <= ended_in;
         left_ff  <= left_in;
         part_ff  <= part_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
      end
   end

endmodule

// File: rtl/ugc_queue.sv
// ----------------------------------------------------------------------------
// ugc_queue: glyph job queue
// Small first-in first-out store that decouples the decoder from the emitter.
// ----------------------------------------------------------------------------
module ugc_queue #(
   parameter int unsigned DEPTH = ugc_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ugc_pkg::glyph_job_type push_job,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output ugc_pkg::glyph_job_type head_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   ugc_pkg::glyph_job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/ugc_back.sv
// ----------------------------------------------------------------------------
// ugc_back: syllable splitter and glyph emitter
// Splits syllables in three stages; one command per cycle unless rsp stalls.
// ----------------------------------------------------------------------------
module ugc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  ugc_pkg::glyph_job_type q_job,
   output logic                   q_pop,
   input  ugc_pkg::csr_type       csr,
   ugc_rsp_if.source              rsp
);

   typedef struct packed {
      logic        hangul;
      logic [13:0] val;
      logic [4:0]  ini;
      logic [9:0]  rem;
      logic [4:0]  med;
      logic [15:0] cur_x;
      logic [15:0] cur_y;
   } split_type;

   typedef struct packed {
      logic        hangul;
      logic [7:0]  code;
      logic [4:0]  ini;
      logic [4:0]  med;
      logic [4:0]  fin;
      logic [15:0] cur_x;
      logic [15:0] cur_y;
   } emit_type;

   split_type s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic      s1_vld_ff, s2_vld_ff, s3_vld_ff;
   emit_type  e_ff, e_in;
   logic      e_vld_ff, e_vld_in;
   ugc_pkg::jamo_slot_type slot_ff, slot_in;

   logic        out_vld_ff, out_vld_in;
   logic        out_font_ff;
   logic [13:0] out_base_ff;
   logic [15:0] out_x_ff, out_y_ff, out_ink_ff;
   logic        out_last_ff;

   logic [28:0] ini_prod;
   logic [13:0] rem_full;
   logic [19:0] med_prod;
   logic [9:0]  fin_full;
   logic        pipe_go, emit, last_now;
   logic [3:0]  set_sel;
   logic [4:0]  jamo_sel;
   logic [13:0] base_now;

   // stage 1: initial = off / 588
   always_comb begin
      ini_prod = 29'(q_job.val) * 29'(ugc_pkg::INI_RECIP);
      s1_in = '0;
      s1_in.hangul = q_job.hangul;
      s1_in.val    = q_job.val;
      s1_in.ini    = ini_prod[ugc_pkg::INI_SHIFT +: 5];
      s1_in.cur_x  = q_job.cur_x;
      s1_in.cur_y  = q_job.cur_y;
   end

   // stage 2: remainder after the initial
   always_comb begin
      rem_full  = s1_ff.val - 14'(s1_ff.ini) * 14'(ugc_pkg::JAMO_PER_INI);
      s2_in     = s1_ff;
      s2_in.rem = rem_full[9:0];
   end

   // stage 3: medial = rem / 28
   always_comb begin
      med_prod  = 20'(s2_ff.rem) * 20'(ugc_pkg::MED_RECIP);
      s3_in     = s2_ff;
      s3_in.med = med_prod[ugc_pkg::MED_SHIFT +: 5];
   end

   // emit stage load: final = rem - 28 * medial
   always_comb begin
      fin_full    = s3_ff.rem - 10'(s3_ff.med) * 10'(ugc_pkg::FIN_PER_MED);
      e_in.hangul = s3_ff.hangul;
      e_in.code   = s3_ff.val[7:0];
      e_in.ini    = s3_ff.ini;
      e_in.med    = s3_ff.med;
      e_in.fin    = fin_full[4:0];
      e_in.cur_x  = s3_ff.cur_x;
      e_in.cur_y  = s3_ff.cur_y;
   end

   assign emit     = e_vld_ff && (!out_vld_ff || rsp.ready);
   assign last_now = !e_ff.hangul || (slot_ff == ugc_pkg::SLOT_FINAL);
   assign pipe_go  = !e_vld_ff || (emit && last_now);
   assign q_pop    = pipe_go && q_valid;

   always_comb begin
      unique case (slot_ff)
         ugc_pkg::SLOT_INITIAL: begin
            set_sel  = ugc_pkg::initial_glyph_set(e_ff.med, e_ff.fin);
            jamo_sel = e_ff.ini;
         end
         ugc_pkg::SLOT_MEDIAL: begin
            set_sel  = ugc_pkg::medial_glyph_set(e_ff.ini, e_ff.fin);
            jamo_sel = e_ff.med;
         end
         ugc_pkg::SLOT_FINAL: begin
            set_sel  = ugc_pkg::final_glyph_set(e_ff.med);
            jamo_sel = e_ff.fin;
         end
         default: begin
            set_sel  = 4'd0;
            jamo_sel = 5'd0;
         end
      endcase
      base_now = e_ff.hangul ? {set_sel, 4'd0, jamo_sel, 1'b0} : {2'd0, e_ff.code, 4'd0};
   end

   always_comb begin
      slot_in  = slot_ff;
      e_vld_in = e_vld_ff;
      if (pipe_go) begin
         slot_in  = ugc_pkg::SLOT_INITIAL;
         e_vld_in = s3_vld_ff;
      end else if (emit) begin
         unique case (slot_ff)
            ugc_pkg::SLOT_INITIAL: slot_in = ugc_pkg::SLOT_MEDIAL;
            ugc_pkg::SLOT_MEDIAL:  slot_in = ugc_pkg::SLOT_FINAL;
            default:               slot_in = ugc_pkg::SLOT_INITIAL;
         endcase
      end
      out_vld_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         e_vld_ff   <= 1'b0;
         slot_ff    <= ugc_pkg::SLOT_INITIAL;
         out_vld_ff <= 1'b0;
      end else begin
         if (pipe_go) begin
            s1_vld_ff <= q_valid;
            s2_vld_ff <= s1_vld_ff;
            s3_vld_ff <= s2_vld_ff;
         end
         e_vld_ff   <= e_vld_in;
         slot_ff    <= slot_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_go) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         e_ff  <= e_in;
      end
      if (emit) begin
         out_font_ff <= e_ff.hangul;
         out_base_ff <= base_now;
         out_x_ff    <= csr.origin_x + e_ff.cur_x;
         out_y_ff    <= csr.origin_y + e_ff.cur_y;
         out_ink_ff  <= csr.ink;
         out_last_ff <= last_now;
      end
   end

   assign rsp.valid       = out_vld_ff;
   assign rsp.font_select = out_font_ff;
   assign rsp.glyph_base  = out_base_ff;
   assign rsp.draw_x      = out_x_ff;
   assign rsp.draw_y      = out_y_ff;
   assign rsp.ink         = out_ink_ff;
   assign rsp.last        = out_last_ff;

endmodule

// File: rtl/utf8_hangul_glyph_composer_unit.sv
// ----------------------------------------------------------------------------
// utf8_hangul_glyph_composer_unit: UTF-8 text to font-ROM glyph commands
// Decodes UTF-8 bytes and issues glyph commands for the 8x16 single-byte font
// and the 8x4x4 Hangul combination font.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   req_chan  in         valid / ready       data_byte, start_req
//   rsp_chan  out        valid / ready       font_select, glyph_base, draw_x,
//                                            draw_y, ink, last
//   csr_*     in         csr_wr_en (no wait) csr_index, csr_wdata
//
// Flow: a byte is taken every cycle while the job queue has room. A single-
//   byte glyph gives one command and a Hangul syllable three, one command per
//   cycle through the single emit stage while rsp_chan is not stalled.
// Path: a glyph job goes from the byte transaction through the queue, three
//   split stages, the emit stage and the output register to rsp_chan.
// Reset: synchronous; no clearing pass is needed.
// Stalls: rsp_chan back-pressure holds the emit stage, then the split stages,
//   then fills the queue; req_chan.ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module utf8_hangul_glyph_composer_unit #(
   parameter int unsigned QUEUE_DEPTH = ugc_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   ugc_req_if.sink                          req_chan,
   ugc_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [ugc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ugc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // configuration registers, written by the user only while idle; not enforced
   ugc_pkg::csr_type csr_ff, csr_in;

   // front to queue, queue to back
   logic                   q_push;
   ugc_pkg::glyph_job_type q_push_job;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_head_valid;
   ugc_pkg::glyph_job_type q_head_job;

   // decode the register index; writes beyond the list are dropped
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ugc_pkg::CSR_ORIGIN_X: csr_in.origin_x = csr_wdata;
            ugc_pkg::CSR_ORIGIN_Y: csr_in.origin_y = csr_wdata;
            ugc_pkg::CSR_INK:      csr_in.ink      = csr_wdata;
            default:               csr_in          = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // decoder: holds the pen and the partial code point, queues glyph jobs
   ugc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (q_push_job)
   );

   // job queue: lets the decoder run ahead while the emitter drains syllables
   ugc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_job   (q_head_job)
   );

   // splitter and emitter: one command per cycle, back-pressure permitting
   ugc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_head_valid),
      .q_job   (q_head_job),
      .q_pop   (q_pop),
      .csr     (csr_ff),
      .rsp     (rsp_chan)
   );

endmodule

// File: rtl/ugc_checker.sv
// ----------------------------------------------------------------------------
// ugc_checker: port-level checks for the glyph composer
// Watches the command channel for ordering and hold behaviour.
// ----------------------------------------------------------------------------
module ugc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        font_select,
   input logic [13:0] glyph_base,
   input logic [15:0] draw_x,
   input logic        last
);

   // a stalled command holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(glyph_base) && $stable(draw_x))
      else $error("rsp command changed while stalled");

   // nothing is offered straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid straight after reset");

   // a command that is not the last of its code point is a Hangul jamo, followed by
   // another jamo at the same pen position
   a_jamo_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last |=> !rsp_valid || (font_select && $stable(draw_x)))
      else $error("jamo sequence broken");

   // the final Hangul jamo comes from the final sets
   a_final_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && font_select && last |-> glyph_base[13:12] == 2'b11)
      else $error("last Hangul command outside the final sets");

   // a single-byte glyph is always the only command of its code point
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !font_select |-> last)
      else $error("single-byte glyph not marked last");

endmodule

bind utf8_hangul_glyph_composer_unit ugc_checker u_ugc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .font_select (rsp_chan.font_select),
   .glyph_base  (rsp_chan.glyph_base),
   .draw_x      (rsp_chan.draw_x),
   .last        (rsp_chan.last)
);

// File: tb/ugc_glyph_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ugc_glyph_checker: glyph command predictor and scoreboard
// Watches the byte and glyph channels and the register port. Runs each accepted
// byte through a decoder of its own, queues the glyph commands it should cause
// and compares every command that leaves the block against the oldest one.
// ----------------------------------------------------------------------------
module ugc_glyph_checker
   import ugc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   ugc_req_if                     req_mon,
   ugc_rsp_if                     rsp_mon,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            error_total,
   output int unsigned            cmds_waiting
);

   typedef struct packed {
      logic        font_select;
      logic [13:0] glyph_base;
      logic [15:0] draw_x;
      logic [15:0] draw_y;
      logic [15:0] ink;
      logic        last;
   } glyph_cmd_type;

   glyph_cmd_type awaited_cmds[$];

   logic [15:0] origin_x, origin_y, ink_colour;
   logic [15:0] pen_x, pen_y, code_acc;
   logic [1:0]  cont_left;
   logic        text_done;

   // set of the initial consonant, chosen by the vowel shape and a final
   function automatic int unsigned lead_glyph_set(int unsigned vowel, int unsigned tail);
      int unsigned row;
      case (vowel)
         8, 12, 18:      row = 1;
         13, 17:         row = 2;
         9, 10, 11, 19:  row = 3;
         14, 15, 16:     row = 4;
         default:        row = 0;
      endcase
      if (tail != 0) begin
         row = (row == 0) ? 5 : (row <= 2) ? 6 : 7;
      end
      return row;
   endfunction

   function automatic int unsigned vowel_glyph_set(int unsigned lead, int unsigned tail);
      return 8 + ((lead == 0 || lead == 15) ? 0 : 1) + ((tail != 0) ? 2 : 0);
   endfunction

   function automatic int unsigned tail_glyph_set(int unsigned vowel);
      case (vowel)
         0, 2, 9:                     return 12;
         4, 6, 11, 14, 16, 19, 20:    return 13;
         1, 3, 5, 7, 10, 15:          return 14;
         default:                     return 15;
      endcase
   endfunction

   function automatic glyph_cmd_type make_cmd(logic font, logic [13:0] base, logic fin);
      glyph_cmd_type c;
      c.font_select = font;
      c.glyph_base  = base;
      c.draw_x      = origin_x + pen_x;
      c.draw_y      = origin_y + pen_y;
      c.ink         = ink_colour;
      c.last        = fin;
      return c;
   endfunction

   task automatic place_code(logic [15:0] code);
      int unsigned offset, lead, vowel, tail;
      if (code == CODE_NUL) begin
         text_done = 1'b1;
      end else if (code >= HANGUL_FIRST && code <= HANGUL_LAST) begin
         offset = int'(code) - int'(HANGUL_FIRST);
         lead   = offset / JAMO_PER_INI;
         vowel  = (offset % JAMO_PER_INI) / FIN_PER_MED;
         tail   = offset % FIN_PER_MED;
         awaited_cmds.push_back(make_cmd(1'b1,
            14'(1024 * lead_glyph_set(vowel, tail) + 2 * lead), 1'b0));
         awaited_cmds.push_back(make_cmd(1'b1,
            14'(1024 * vowel_glyph_set(lead, tail) + 2 * vowel), 1'b0));
         awaited_cmds.push_back(make_cmd(1'b1,
            14'(1024 * tail_glyph_set(vowel) + 2 * tail), 1'b1));
         pen_x = pen_x + STEP_HANGUL;
      end else if (code == CODE_LF) begin
         pen_y = pen_y + STEP_LINE;
      end else if (code == CODE_CR) begin
         pen_x = '0;
      end else if (code < SINGLE_LIMIT) begin
         awaited_cmds.push_back(make_cmd(1'b0, {2'b00, code[7:0], 4'b0000}, 1'b1));
         pen_x = pen_x + STEP_SINGLE;
      end
   endtask

   task automatic decode_byte(logic [7:0] b, logic restart);
      if (restart) begin
         pen_x     = '0;
         pen_y     = '0;
         code_acc  = '0;
         cont_left = '0;
         text_done = 1'b0;
      end
      if (!text_done) begin
         if (cont_left != 0) begin
            // continuation bytes are taken on trust, whatever their top bits
            code_acc  = {code_acc[9:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 0) begin
               place_code(code_acc);
            end
         end else if (b < BYTE_ASCII_END) begin
            place_code({8'h00, b});
         end else if (b < BYTE_LEAD2 || b > BYTE_LEAD4) begin
            text_done = 1'b1;
         end else if (b < BYTE_LEAD3) begin
            code_acc  = {11'd0, b[4:0]};
            cont_left = 2'd1;
         end else if (b < BYTE_LEAD4) begin
            code_acc  = {12'd0, b[3:0]};
            cont_left = 2'd2;
         end else begin
            code_acc  = '0;
            cont_left = 2'd3;
         end
      end
   endtask

   function automatic int unsigned check_field(string name, longint unsigned want,
                                               longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      glyph_cmd_type want;
      int unsigned   errs;
      errs = 0;
      if (reset) begin
         origin_x     = '0;
         origin_y     = '0;
         ink_colour   = '0;
         pen_x        = '0;
         pen_y        = '0;
         code_acc     = '0;
         cont_left    = '0;
         text_done    = 1'b0;
         awaited_cmds.delete();
         error_total  <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ORIGIN_X: origin_x   = csr_wdata;
               CSR_ORIGIN_Y: origin_y   = csr_wdata;
               CSR_INK:      ink_colour = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_cmds.size() == 0) begin
               $error("glyph command with none expected: base 0x%0h at (%0d,%0d)",
                      rsp_mon.glyph_base, rsp_mon.draw_x, rsp_mon.draw_y);
               errs = errs + 1;
            end else begin
               want = awaited_cmds.pop_front();
               errs = errs + check_field("font_select", want.font_select,
                                         rsp_mon.font_select);
               errs = errs + check_field("glyph_base", want.glyph_base, rsp_mon.glyph_base);
               errs = errs + check_field("draw_x", want.draw_x, rsp_mon.draw_x);
               errs = errs + check_field("draw_y", want.draw_y, rsp_mon.draw_y);
               errs = errs + check_field("ink", want.ink, rsp_mon.ink);
               errs = errs + check_field("last", want.last, rsp_mon.last);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            decode_byte(req_mon.data_byte, req_mon.start_req);
         end
         error_total <= error_total + errs;
      end
      cmds_waiting <= awaited_cmds.size();
   end

endmodule

// File: tb/utf8_hangul_glyph_composer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_hangul_glyph_composer_unit_tb: glyph composer testbench
// Feeds UTF-8 byte streams into the composer: a directed set of corner cases,
// a short run with the origin at the top of the range so draw positions wrap,
// then random text made mostly of well-formed sequences. A side checker
// predicts and compares every glyph command; this module drives stimulus,
// back-pressure and gives the verdict.
// ----------------------------------------------------------------------------
module utf8_hangul_glyph_composer_unit_tb;
   import ugc_pkg::*;

   // quiet cycles (nothing accepted on either channel) before giving up
   localparam int unsigned STALL_LIMIT = 1000;
   // cycles to let the pipeline drain of bytes that cause no command
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned ITEMS_PER_PHASE = 92;

   logic clock;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ugc_req_if req_chan ();
   ugc_rsp_if rsp_chan ();

   int unsigned error_total;
   int unsigned cmds_waiting;
   int unsigned sent_items;
   int unsigned quiet_cycles;
   int unsigned rsp_hold;
   logic        steady_flow;   // when set, neither side inserts idle cycles
   logic        restart_due;   // next sequence must carry start_req

   utf8_hangul_glyph_composer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ugc_glyph_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_total  (error_total),
      .cmds_waiting (cmds_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Glyph sink: after each accepted command draw a random stall length,
   // hold ready low for that long, then raise it again.
   always @(posedge clock) begin
      int unsigned stall;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold       <= 0;
      end else if (rsp_hold != 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold       <= rsp_hold - 1;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         stall = steady_flow ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold       <= stall - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Watchdog: any transaction on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one byte after a random gap and hold it until the block takes it.
   // Valid stays high on return so back-to-back bytes need no extra edge.
   task automatic send_byte(logic [7:0] b, logic restart);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.start_req <= restart;
      do @(posedge clock); while (!req_chan.ready);
      sent_items++;
   endtask

   // Encode a code point of up to 16 bits as 1, 2 or 3 UTF-8 bytes.
   task automatic send_utf8(logic [15:0] code, logic restart);
      if (code < 16'h0080) begin
         send_byte(code[7:0], restart);
      end else if (code < 16'h0800) begin
         send_byte({3'b110, code[10:6]}, restart);
         send_byte({2'b10, code[5:0]}, 1'b0);
      end else begin
         send_byte({4'b1110, code[15:12]}, restart);
         send_byte({2'b10, code[11:6]}, 1'b0);
         send_byte({2'b10, code[5:0]}, 1'b0);
      end
   endtask

   // Drop valid and wait until every predicted command has left the block,
   // then let any byte still in the pipeline with no command drain out.
   // One edge first so the count includes the last byte sent.
   task automatic drain_block();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (cmds_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all three registers on consecutive edges; only called when idle.
   task automatic program_regs(logic [15:0] ox, logic [15:0] oy, logic [15:0] colour);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ORIGIN_X;
      csr_wdata <= ox;
      @(posedge clock);
      csr_index <= CSR_ORIGIN_Y;
      csr_wdata <= oy;
      @(posedge clock);
      csr_index <= CSR_INK;
      csr_wdata <= colour;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One random piece of text. Most pieces are well-formed; a few are cut
   // short or plain noise, and those force a fresh start on the next piece.
   task automatic send_random_piece();
      int unsigned pick, sub;
      logic        restart;
      logic [7:0]  b0, b1, b2, b3;
      restart     = restart_due || ($urandom_range(0, 99) < 6);
      restart_due = 1'b0;
      pick        = $urandom_range(0, 99);
      b1 = $urandom_range(0, 99) < 80 ? 8'($urandom_range(8'h80, 8'hBF))
                                      : 8'($urandom_range(0, 255));
      b2 = 8'($urandom_range(0, 255));
      b3 = 8'($urandom_range(0, 255));
      if (pick < 35) begin
         send_utf8(16'($urandom_range(HANGUL_FIRST, HANGUL_LAST)), restart);
      end else if (pick < 60) begin
         sub = $urandom_range(0, 99);
         if (sub < 10) begin
            send_byte(CODE_LF[7:0], restart);
         end else if (sub < 18) begin
            send_byte(CODE_CR[7:0], restart);
         end else begin
            send_byte(8'($urandom_range(1, 8'h7F)), restart);
         end
      end else if (pick < 70) begin
         b0 = 8'($urandom_range(8'hC0, 8'hDF));
         send_byte(b0, restart);
         send_byte(b1, 1'b0);
         restart_due = ({b0[4:0], b1[5:0]} == 11'd0);
      end else if (pick < 78) begin
         b0 = 8'($urandom_range(8'hE0, 8'hEF));
         send_byte(b0, restart);
         send_byte(b1, 1'b0);
         send_byte(b2, 1'b0);
         restart_due = ({b0[3:0], b1[5:0], b2[5:0]} == 16'd0);
      end else if (pick < 84) begin
         // four-byte form: only the low 16 bits of the code survive
         send_byte(BYTE_LEAD4, restart);
         send_byte(b1, 1'b0);
         send_byte(b2, 1'b0);
         send_byte(b3, 1'b0);
         restart_due = ({b1[3:0], b2[5:0], b3[5:0]} == 16'd0);
      end else if (pick < 92) begin
         // short sequence: a lead and maybe one continuation, then restart
         send_byte(8'($urandom_range(BYTE_LEAD2, BYTE_LEAD4)), restart);
         if ($urandom_range(0, 1) != 0) begin
            send_byte(b1, 1'b0);
         end
         restart_due = 1'b1;
      end else begin
         send_byte(8'($urandom_range(0, 255)), restart);
         restart_due = 1'b1;
      end
   endtask

   initial begin
      logic [15:0] ox, oy, colour;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= '0;
      req_chan.start_req <= 1'b0;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_ORIGIN_X;
      csr_wdata          <= '0;
      steady_flow        = 1'b0;
      restart_due        = 1'b0;
      sent_items         = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed corner cases ----
      program_regs(16'h0010, 16'h0020, 16'hA5A5);
      send_byte(8'h41, 1'b1);             // plain single-byte glyph
      send_byte(CODE_CR[7:0], 1'b0);      // carriage return, no command
      send_byte(8'h7F, 1'b0);             // top of the ASCII range
      send_utf8(16'h00E9, 1'b0);          // two-byte code under 0x100
      send_utf8(16'h0430, 1'b0);          // other code point: ignored
      send_utf8(HANGUL_FIRST, 1'b0);
      send_utf8(HANGUL_LAST, 1'b0);
      // four-byte form whose low 16 bits land on the first syllable
      send_byte(BYTE_LEAD4, 1'b0);
      send_byte(8'h8A, 1'b0);
      send_byte(8'hB0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hC2, 1'b0);             // NUL taken as a continuation
      send_byte(8'h00, 1'b0);
      send_byte(8'hC0, 1'b0);             // completed code of zero ends text
      send_byte(8'h80, 1'b0);
      send_byte(8'h42, 1'b0);             // ignored while text has ended
      send_byte(8'h80, 1'b1);             // stray continuation ends text
      send_byte(8'hFF, 1'b1);             // lead above 0xF0 ends text
      send_byte(8'h00, 1'b1);             // NUL ends text
      send_byte(8'h43, 1'b1);             // fresh start after the end mark
      drain_block();

      // ---- wrap: origin at the top of the range so draw positions wrap ----
      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
      steady_flow = 1'b1;
      send_byte(8'h41, 1'b1);
      repeat (3) send_byte(CODE_LF[7:0], 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(CODE_LF[7:0], 1'b0);
      send_byte(8'h5A, 1'b0);
      send_utf8(16'hD55C, 1'b0);
      steady_flow = 1'b0;
      drain_block();

      // ---- random text in four register settings ----
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin ox = '0; oy = '0; colour = '0; end
            1: begin ox = '1; oy = '1; colour = '1; end
            default: begin
               ox     = 16'($urandom_range(0, 16'hFFFF));
               oy     = 16'($urandom_range(0, 16'hFFFF));
               colour = 16'($urandom_range(0, 16'hFFFF));
            end
         endcase
         program_regs(ox, oy, colour);
         steady_flow = (phase == 2);
         restart_due = 1'b1;
         sent_items  = 0;
         while (sent_items < ITEMS_PER_PHASE) begin
            send_random_piece();
            // just past mid-phase, hold the sender until the block empties
            if (phase == 1 && sent_items >= ITEMS_PER_PHASE / 2 &&
                sent_items < ITEMS_PER_PHASE / 2 + 4) begin
               drain_block();
            end
         end
         drain_block();
      end

      if (error_total == 0 && cmds_waiting == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
